// ===== sv/body_velocity_integrator_2d_core_assert.svh =====
// Assertion macros for the body velocity integrator core.
`ifndef BODY_VELOCITY_INTEGRATOR_2D_CORE_ASSERT_SVH
`define BODY_VELOCITY_INTEGRATOR_2D_CORE_ASSERT_SVH
`ifndef SYNTH
`define BVI2D_ASSERT_SAME(label, ant, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error("assertion failed");
`define BVI2D_ASSERT_NEXT(label, ant, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error("assertion failed");
`else
`define BVI2D_ASSERT_SAME(label, ant, cons)
`define BVI2D_ASSERT_NEXT(label, ant, cons)
`endif
`endif

// ===== sv/bvi2d_pkg.sv =====
package bvi2d_pkg;

	typedef struct packed {
		logic [2:0]         mode;
		logic signed [31:0] x_value;
		logic signed [31:0] y_value;
		logic signed [31:0] amount;
		logic [16:0]        step_seconds;
	} in_t;

	typedef struct packed {
		logic signed [31:0] velocity_x;
		logic signed [31:0] velocity_y;
		logic signed [31:0] move_x;
		logic signed [31:0] move_y;
		logic               speed_limited;
	} out_t;

	localparam logic [2:0] MODE_FORCE   = 3'd0;
	localparam logic [2:0] MODE_IMPULSE = 3'd1;
	localparam logic [2:0] MODE_STEP    = 3'd2;
	localparam logic [2:0] MODE_SETV    = 3'd3;
	localparam logic [2:0] MODE_CLAMP   = 3'd4;
	localparam logic [2:0] MODE_CLEAR   = 3'd5;

	localparam logic [1:0] REG_INV_MASS  = 2'd0;
	localparam logic [1:0] REG_MAX_SPEED = 2'd1;
	localparam logic [1:0] REG_DRAG      = 2'd2;

	localparam logic [30:0] INV_MASS_RST  = 31'd65536;
	localparam logic [30:0] MAX_SPEED_RST = 31'd6553600;
	localparam logic [30:0] DRAG_RST      = 31'd0;

	localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] Q_MIN = 32'sh80000000;

	typedef enum logic [4:0] {
		SRC_ZERO, SRC_XV, SRC_YV, SRC_AMT, SRC_DT, SRC_IM, SRC_DR, SRC_MS,
		SRC_VX, SRC_VY, SRC_AX, SRC_AY, SRC_BX, SRC_BY, SRC_T, SRC_K,
		SRC_L, SRC_MAGX, SRC_MAGY
	} src_t;

	typedef enum logic [3:0] {
		WB_NONE, WB_T, WB_TNEG, WB_K, WB_ADD_AX, WB_ADD_AY, WB_ADD_VX,
		WB_ADD_VY, WB_SQ, WB_SQ_ADD, WB_CMP, WB_MVX, WB_MVY
	} wb_t;

	typedef enum logic [3:0] {
		MISC_NONE, MISC_LOAD, MISC_SETV, MISC_CLR, MISC_BSAVE, MISC_L_AMT,
		MISC_SQRT, MISC_N_SAVE, MISC_L_SAVE, MISC_DIV, MISC_QX, MISC_QY,
		MISC_CLRA, MISC_PUBLISH
	} misc_t;

	typedef struct packed {
		src_t  src_a;
		src_t  src_b;
		wb_t   wb;
		misc_t misc;
	} cmd_t;

	typedef struct packed {
		logic       sqrt_done;
		logic       div_done;
		logic       gt;
		logic [2:0] mode;
	} sts_t;

	typedef enum logic [5:0] {
		ST_IDLE, ST_DISP,
		ST_M0_A, ST_M0_B, ST_M0_C,
		ST_M1_A, ST_M1_B, ST_M1_C, ST_M1_D, ST_M1_E,
		ST_M2_A, ST_M2_B, ST_M2_C, ST_M2_D, ST_M2_E, ST_M2_F, ST_M2_G, ST_M2_H,
		ST_M2_I, ST_M2_J, ST_M2_K, ST_M2_L, ST_M2_M, ST_M2_N, ST_M2_O, ST_M2_P,
		ST_C_A, ST_C_B, ST_C_C, ST_C_D, ST_C_E, ST_C_F,
		ST_R_SQ, ST_R_SQW, ST_L_A, ST_L_B, ST_L_C, ST_L_D, ST_L_E,
		ST_RX_A, ST_RX_B, ST_RX_C, ST_RY_A, ST_RY_B, ST_RY_C,
		ST_MV_A, ST_MV_B, ST_MV_C, ST_FIN
	} state_t;

	function automatic logic signed [31:0] sat_q(input logic signed [65:0] p);
		logic signed [49:0] f;
		f = p[65:16];
		if (f[49:31] == {19{f[49]}})
			return f[31:0];
		return f[49] ? Q_MIN : Q_MAX;
	endfunction

	function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [32:0] s;
		s = {a[31], a} + {b[31], b};
		if (s[32] != s[31])
			return s[32] ? Q_MIN : Q_MAX;
		return s[31:0];
	endfunction

	function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
		if (v[33:31] == {3{v[33]}})
			return v[31:0];
		return v[33] ? Q_MIN : Q_MAX;
	endfunction

endpackage

// ===== sv/body_velocity_integrator_2d_core.sv =====
// From acceptance, set, clear and unused modes go straight to the result; force and impulse
// run a short multiply sequence, and clamp and step compare the squared speed with the limit;
// a rescaling clamp runs one square root and a limited step two, each followed by two divides.
// One item is in work at a time; the next can be taken in the cycle after its result is registered.
// The shared 33x33 multiplier and the one-bit-a-cycle square root and divider set each item's duration.
// Reset: asynchronous, active low; velocity and acceleration clear, registers take defaults.
module body_velocity_integrator_2d_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  bvi2d_pkg::in_t   in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output bvi2d_pkg::out_t  out_data,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [31:0]      cfg_data
);
	`include "body_velocity_integrator_2d_core_assert.svh"

	bvi2d_pkg::cmd_t ctl_cmd;
	bvi2d_pkg::sts_t dp_sts;

	assign cfg_ready = 1'b1;

	bvi2d_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (dp_sts),
		.cmd       (ctl_cmd)
	);

	bvi2d_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (ctl_cmd),
		.sts       (dp_sts),
		.in_data   (in_data),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_data  (out_data)
	);

	`BVI2D_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
	`BVI2D_ASSERT_NEXT(a_publish_valid, ctl_cmd.misc == bvi2d_pkg::MISC_PUBLISH, out_valid)
	`BVI2D_ASSERT_SAME(a_idle_no_writeback, in_ready, ctl_cmd.wb == bvi2d_pkg::WB_NONE)
endmodule

// ===== sv/bvi2d_isqrt.sv =====
module bvi2d_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] radicand,
	output logic        done,
	output logic [31:0] root
);
	logic [63:0] rem_q, res_q, bit_q, trial;
	logic [4:0]  cnt_q;
	logic        busy_q, done_q;

	assign trial = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= radicand;
			res_q <= '0;
			bit_q <= 64'h4000_0000_0000_0000;
		end else if (busy_q) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[31:0];
endmodule

// ===== sv/bvi2d_div.sv =====
module bvi2d_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [63:0] quotient
);
	logic [63:0] num_q, quo_q;
	logic [31:0] rem_q, den_q;
	logic [32:0] trial;
	logic        fits;
	logic [5:0]  cnt_q;
	logic        busy_q, done_q;

	assign trial = {rem_q, num_q[63]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? 32'(trial - {1'b0, den_q}) : trial[31:0];
			num_q <= {num_q[62:0], 1'b0};
			quo_q <= {quo_q[62:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

// ===== sv/bvi2d_datapath.sv =====
module bvi2d_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  bvi2d_pkg::cmd_t   cmd,
	output bvi2d_pkg::sts_t   sts,
	input  bvi2d_pkg::in_t    in_data,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [31:0]       cfg_data,
	output bvi2d_pkg::out_t   out_data
);
	bvi2d_pkg::in_t     in_q;
	bvi2d_pkg::out_t    out_q;
	logic [30:0]        im_q, ms_q, dr_q;
	logic signed [31:0] vx_q, vy_q, ax_q, ay_q, bx_q, by_q, t_q, k_q, mvx_q, mvy_q;
	logic [31:0]        l_q, n_q;
	logic [63:0]        sq_q;
	logic               gt_q, lim_q;
	logic signed [65:0] prod_s1;
	logic signed [32:0] op_a, op_b;
	logic signed [31:0] qs, qneg, resc;
	logic               sqrt_done, div_done;
	logic [31:0]        root;
	logic [63:0]        quo;
	logic [32:0]        qc;
	logic               rneg;

	function automatic logic signed [32:0] pick(input bvi2d_pkg::src_t s,
		input bvi2d_pkg::in_t i, input logic [30:0] im, input logic [30:0] dr,
		input logic [30:0] ms, input logic signed [31:0] vx, input logic signed [31:0] vy,
		input logic signed [31:0] ax, input logic signed [31:0] ay,
		input logic signed [31:0] bx, input logic signed [31:0] by,
		input logic signed [31:0] t, input logic signed [31:0] k, input logic [31:0] l);
		logic signed [32:0] r;
		case (s)
			bvi2d_pkg::SRC_XV:   r = {i.x_value[31], i.x_value};
			bvi2d_pkg::SRC_YV:   r = {i.y_value[31], i.y_value};
			bvi2d_pkg::SRC_AMT:  r = {i.amount[31], i.amount};
			bvi2d_pkg::SRC_DT:   r = {16'd0, i.step_seconds};
			bvi2d_pkg::SRC_IM:   r = {2'b00, im};
			bvi2d_pkg::SRC_DR:   r = {2'b00, dr};
			bvi2d_pkg::SRC_MS:   r = {2'b00, ms};
			bvi2d_pkg::SRC_VX:   r = {vx[31], vx};
			bvi2d_pkg::SRC_VY:   r = {vy[31], vy};
			bvi2d_pkg::SRC_AX:   r = {ax[31], ax};
			bvi2d_pkg::SRC_AY:   r = {ay[31], ay};
			bvi2d_pkg::SRC_BX:   r = {bx[31], bx};
			bvi2d_pkg::SRC_BY:   r = {by[31], by};
			bvi2d_pkg::SRC_T:    r = {t[31], t};
			bvi2d_pkg::SRC_K:    r = {k[31], k};
			bvi2d_pkg::SRC_L:    r = {1'b0, l};
			bvi2d_pkg::SRC_MAGX: r = vx[31] ? -{vx[31], vx} : {vx[31], vx};
			bvi2d_pkg::SRC_MAGY: r = vy[31] ? -{vy[31], vy} : {vy[31], vy};
			default:             r = '0;
		endcase
		return r;
	endfunction

	assign op_a = pick(cmd.src_a, in_q, im_q, dr_q, ms_q, vx_q, vy_q, ax_q, ay_q,
		bx_q, by_q, t_q, k_q, l_q);
	assign op_b = pick(cmd.src_b, in_q, im_q, dr_q, ms_q, vx_q, vy_q, ax_q, ay_q,
		bx_q, by_q, t_q, k_q, l_q);

	assign qs   = bvi2d_pkg::sat_q(prod_s1);
	assign qneg = (qs == bvi2d_pkg::Q_MIN) ? bvi2d_pkg::Q_MAX : -qs;

	assign qc   = (quo > 64'h1_0000_0000) ? 33'h1_0000_0000 : quo[32:0];
	assign rneg = ((cmd.misc == bvi2d_pkg::MISC_QX) ? vx_q[31] : vy_q[31])
		^ (in_q.mode == bvi2d_pkg::MODE_CLAMP && in_q.amount[31]);
	assign resc = bvi2d_pkg::sat34(rneg ? -{1'b0, qc} : {1'b0, qc});

	bvi2d_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.misc == bvi2d_pkg::MISC_SQRT),
		.radicand (sq_q),
		.done     (sqrt_done),
		.root     (root)
	);

	bvi2d_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.misc == bvi2d_pkg::MISC_DIV),
		.dividend (prod_s1[63:0]),
		.divisor  (n_q),
		.done     (div_done),
		.quotient (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			im_q <= bvi2d_pkg::INV_MASS_RST;
			ms_q <= bvi2d_pkg::MAX_SPEED_RST;
			dr_q <= bvi2d_pkg::DRAG_RST;
			vx_q <= '0;
			vy_q <= '0;
			ax_q <= '0;
			ay_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					bvi2d_pkg::REG_INV_MASS:  im_q <= cfg_data[30:0];
					bvi2d_pkg::REG_MAX_SPEED: ms_q <= cfg_data[30:0];
					bvi2d_pkg::REG_DRAG:      dr_q <= cfg_data[30:0];
					default: ;
				endcase
			end
			case (cmd.wb)
				bvi2d_pkg::WB_ADD_AX: ax_q <= bvi2d_pkg::add_sat(ax_q, qs);
				bvi2d_pkg::WB_ADD_AY: ay_q <= bvi2d_pkg::add_sat(ay_q, qs);
				bvi2d_pkg::WB_ADD_VX: vx_q <= bvi2d_pkg::add_sat(vx_q, qs);
				bvi2d_pkg::WB_ADD_VY: vy_q <= bvi2d_pkg::add_sat(vy_q, qs);
				default: ;
			endcase
			case (cmd.misc)
				bvi2d_pkg::MISC_SETV: begin
					vx_q <= in_q.x_value;
					vy_q <= in_q.y_value;
				end
				bvi2d_pkg::MISC_CLR: begin
					vx_q <= '0;
					vy_q <= '0;
					ax_q <= '0;
					ay_q <= '0;
				end
				bvi2d_pkg::MISC_CLRA: begin
					ax_q <= '0;
					ay_q <= '0;
				end
				bvi2d_pkg::MISC_QX: vx_q <= resc;
				bvi2d_pkg::MISC_QY: vy_q <= resc;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
		case (cmd.wb)
			bvi2d_pkg::WB_T:      t_q   <= qs;
			bvi2d_pkg::WB_TNEG:   t_q   <= qneg;
			bvi2d_pkg::WB_K:      k_q   <= qs;
			bvi2d_pkg::WB_SQ:     sq_q  <= prod_s1[63:0];
			bvi2d_pkg::WB_SQ_ADD: sq_q  <= sq_q + prod_s1[63:0];
			bvi2d_pkg::WB_CMP:    gt_q  <= sq_q > prod_s1[63:0];
			bvi2d_pkg::WB_MVX:    mvx_q <= qs;
			bvi2d_pkg::WB_MVY:    mvy_q <= qs;
			default: ;
		endcase
		case (cmd.misc)
			bvi2d_pkg::MISC_LOAD: begin
				in_q  <= in_data;
				mvx_q <= '0;
				mvy_q <= '0;
				lim_q <= 1'b0;
			end
			bvi2d_pkg::MISC_BSAVE: begin
				bx_q <= vx_q;
				by_q <= vy_q;
			end
			bvi2d_pkg::MISC_L_AMT:
				l_q <= in_q.amount[31] ? 32'(-in_q.amount) : in_q.amount;
			bvi2d_pkg::MISC_N_SAVE: n_q <= (root == '0) ? 32'd1 : root;
			bvi2d_pkg::MISC_L_SAVE: l_q <= root;
			bvi2d_pkg::MISC_QY:     lim_q <= 1'b1;
			bvi2d_pkg::MISC_PUBLISH: begin
				out_q.velocity_x    <= vx_q;
				out_q.velocity_y    <= vy_q;
				out_q.move_x        <= mvx_q;
				out_q.move_y        <= mvy_q;
				out_q.speed_limited <= lim_q;
			end
			default: ;
		endcase
	end

	assign sts.sqrt_done = sqrt_done;
	assign sts.div_done  = div_done;
	assign sts.gt        = gt_q;
	assign sts.mode      = in_q.mode;
	assign out_data      = out_q;
endmodule

// ===== sv/bvi2d_ctrl.sv =====
module bvi2d_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  bvi2d_pkg::sts_t sts,
	output bvi2d_pkg::cmd_t cmd
);
	bvi2d_pkg::state_t state_q, state_d;
	logic              out_valid_q;
	logic              is_step;

	assign is_step = sts.mode == bvi2d_pkg::MODE_STEP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bvi2d_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.misc == bvi2d_pkg::MISC_PUBLISH)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			bvi2d_pkg::ST_IDLE: if (in_valid) state_d = bvi2d_pkg::ST_DISP;
			bvi2d_pkg::ST_DISP: begin
				case (sts.mode)
					bvi2d_pkg::MODE_FORCE:   state_d = bvi2d_pkg::ST_M0_A;
					bvi2d_pkg::MODE_IMPULSE: state_d = bvi2d_pkg::ST_M1_A;
					bvi2d_pkg::MODE_STEP:    state_d = bvi2d_pkg::ST_M2_A;
					bvi2d_pkg::MODE_CLAMP:   state_d = bvi2d_pkg::ST_C_A;
					default:                 state_d = bvi2d_pkg::ST_FIN;
				endcase
			end
			bvi2d_pkg::ST_M0_A: state_d = bvi2d_pkg::ST_M0_B;
			bvi2d_pkg::ST_M0_B: state_d = bvi2d_pkg::ST_M0_C;
			bvi2d_pkg::ST_M0_C: state_d = bvi2d_pkg::ST_FIN;
			bvi2d_pkg::ST_M1_A: state_d = bvi2d_pkg::ST_M1_B;
			bvi2d_pkg::ST_M1_B: state_d = bvi2d_pkg::ST_M1_C;
			bvi2d_pkg::ST_M1_C: state_d = bvi2d_pkg::ST_M1_D;
			bvi2d_pkg::ST_M1_D: state_d = bvi2d_pkg::ST_M1_E;
			bvi2d_pkg::ST_M1_E: state_d = bvi2d_pkg::ST_FIN;
			bvi2d_pkg::ST_M2_A: state_d = bvi2d_pkg::ST_M2_B;
			bvi2d_pkg::ST_M2_B: state_d = bvi2d_pkg::ST_M2_C;
			bvi2d_pkg::ST_M2_C: state_d = bvi2d_pkg::ST_M2_D;
			bvi2d_pkg::ST_M2_D: state_d = bvi2d_pkg::ST_M2_E;
			bvi2d_pkg::ST_M2_E: state_d = bvi2d_pkg::ST_M2_F;
			bvi2d_pkg::ST_M2_F: state_d = bvi2d_pkg::ST_M2_G;
			bvi2d_pkg::ST_M2_G: state_d = bvi2d_pkg::ST_M2_H;
			bvi2d_pkg::ST_M2_H: state_d = bvi2d_pkg::ST_M2_I;
			bvi2d_pkg::ST_M2_I: state_d = bvi2d_pkg::ST_M2_J;
			bvi2d_pkg::ST_M2_J: state_d = bvi2d_pkg::ST_M2_K;
			bvi2d_pkg::ST_M2_K: state_d = bvi2d_pkg::ST_M2_L;
			bvi2d_pkg::ST_M2_L: state_d = bvi2d_pkg::ST_M2_M;
			bvi2d_pkg::ST_M2_M: state_d = bvi2d_pkg::ST_M2_N;
			bvi2d_pkg::ST_M2_N: state_d = bvi2d_pkg::ST_M2_O;
			bvi2d_pkg::ST_M2_O: state_d = bvi2d_pkg::ST_M2_P;
			bvi2d_pkg::ST_M2_P: state_d = sts.gt ? bvi2d_pkg::ST_R_SQ : bvi2d_pkg::ST_MV_A;
			bvi2d_pkg::ST_C_A:  state_d = bvi2d_pkg::ST_C_B;
			bvi2d_pkg::ST_C_B:  state_d = bvi2d_pkg::ST_C_C;
			bvi2d_pkg::ST_C_C:  state_d = bvi2d_pkg::ST_C_D;
			bvi2d_pkg::ST_C_D:  state_d = bvi2d_pkg::ST_C_E;
			bvi2d_pkg::ST_C_E:  state_d = bvi2d_pkg::ST_C_F;
			bvi2d_pkg::ST_C_F:  state_d = sts.gt ? bvi2d_pkg::ST_R_SQ : bvi2d_pkg::ST_FIN;
			bvi2d_pkg::ST_R_SQ: state_d = bvi2d_pkg::ST_R_SQW;
			bvi2d_pkg::ST_R_SQW:
				if (sts.sqrt_done)
					state_d = is_step ? bvi2d_pkg::ST_L_A : bvi2d_pkg::ST_RX_A;
			bvi2d_pkg::ST_L_A:  state_d = bvi2d_pkg::ST_L_B;
			bvi2d_pkg::ST_L_B:  state_d = bvi2d_pkg::ST_L_C;
			bvi2d_pkg::ST_L_C:  state_d = bvi2d_pkg::ST_L_D;
			bvi2d_pkg::ST_L_D:  state_d = bvi2d_pkg::ST_L_E;
			bvi2d_pkg::ST_L_E:  if (sts.sqrt_done) state_d = bvi2d_pkg::ST_RX_A;
			bvi2d_pkg::ST_RX_A: state_d = bvi2d_pkg::ST_RX_B;
			bvi2d_pkg::ST_RX_B: state_d = bvi2d_pkg::ST_RX_C;
			bvi2d_pkg::ST_RX_C: if (sts.div_done) state_d = bvi2d_pkg::ST_RY_A;
			bvi2d_pkg::ST_RY_A: state_d = bvi2d_pkg::ST_RY_B;
			bvi2d_pkg::ST_RY_B: state_d = bvi2d_pkg::ST_RY_C;
			bvi2d_pkg::ST_RY_C:
				if (sts.div_done)
					state_d = is_step ? bvi2d_pkg::ST_MV_A : bvi2d_pkg::ST_FIN;
			bvi2d_pkg::ST_MV_A: state_d = bvi2d_pkg::ST_MV_B;
			bvi2d_pkg::ST_MV_B: state_d = bvi2d_pkg::ST_MV_C;
			bvi2d_pkg::ST_MV_C: state_d = bvi2d_pkg::ST_FIN;
			bvi2d_pkg::ST_FIN:  if (!out_valid_q || out_ready) state_d = bvi2d_pkg::ST_IDLE;
			default:            state_d = bvi2d_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.src_a = bvi2d_pkg::SRC_ZERO;
		cmd.src_b = bvi2d_pkg::SRC_ZERO;
		cmd.wb    = bvi2d_pkg::WB_NONE;
		cmd.misc  = bvi2d_pkg::MISC_NONE;
		case (state_q)
			bvi2d_pkg::ST_IDLE: if (in_valid) cmd.misc = bvi2d_pkg::MISC_LOAD;
			bvi2d_pkg::ST_DISP: begin
				if (sts.mode == bvi2d_pkg::MODE_SETV)
					cmd.misc = bvi2d_pkg::MISC_SETV;
				else if (sts.mode == bvi2d_pkg::MODE_CLEAR)
					cmd.misc = bvi2d_pkg::MISC_CLR;
			end
			bvi2d_pkg::ST_M0_A: begin
				cmd.src_a = bvi2d_pkg::SRC_XV;
				cmd.src_b = bvi2d_pkg::SRC_IM;
			end
			bvi2d_pkg::ST_M0_B: begin
				cmd.wb    = bvi2d_pkg::WB_ADD_AX;
				cmd.src_a = bvi2d_pkg::SRC_YV;
				cmd.src_b = bvi2d_pkg::SRC_IM;
			end
			bvi2d_pkg::ST_M0_C: cmd.wb = bvi2d_pkg::WB_ADD_AY;
			bvi2d_pkg::ST_M1_A: begin
				cmd.src_a = bvi2d_pkg::SRC_AMT;
				cmd.src_b = bvi2d_pkg::SRC_IM;
			end
			bvi2d_pkg::ST_M1_B: cmd.wb = bvi2d_pkg::WB_T;
			bvi2d_pkg::ST_M1_C: begin
				cmd.src_a = bvi2d_pkg::SRC_T;
				cmd.src_b = bvi2d_pkg::SRC_XV;
			end
			bvi2d_pkg::ST_M1_D: begin
				cmd.wb    = bvi2d_pkg::WB_ADD_VX;
				cmd.src_a = bvi2d_pkg::SRC_T;
				cmd.src_b = bvi2d_pkg::SRC_YV;
			end
			bvi2d_pkg::ST_M1_E: cmd.wb = bvi2d_pkg::WB_ADD_VY;
			bvi2d_pkg::ST_M2_A: begin
				cmd.src_a = bvi2d_pkg::SRC_DT;
				cmd.src_b = bvi2d_pkg::SRC_IM;
			end
			bvi2d_pkg::ST_M2_B: begin
				cmd.wb    = bvi2d_pkg::WB_K;
				cmd.src_a = bvi2d_pkg::SRC_VX;
				cmd.src_b = bvi2d_pkg::SRC_DR;
			end
			bvi2d_pkg::ST_M2_C: cmd.wb = bvi2d_pkg::WB_TNEG;
			bvi2d_pkg::ST_M2_D: begin
				cmd.src_a = bvi2d_pkg::SRC_T;
				cmd.src_b = bvi2d_pkg::SRC_K;
			end
			bvi2d_pkg::ST_M2_E: begin
				cmd.wb    = bvi2d_pkg::WB_ADD_VX;
				cmd.src_a = bvi2d_pkg::SRC_VY;
				cmd.src_b = bvi2d_pkg::SRC_DR;
			end
			bvi2d_pkg::ST_M2_F: cmd.wb = bvi2d_pkg::WB_TNEG;
			bvi2d_pkg::ST_M2_G: begin
				cmd.src_a = bvi2d_pkg::SRC_T;
				cmd.src_b = bvi2d_pkg::SRC_K;
			end
			bvi2d_pkg::ST_M2_H: cmd.wb = bvi2d_pkg::WB_ADD_VY;
			bvi2d_pkg::ST_M2_I: begin
				cmd.misc  = bvi2d_pkg::MISC_BSAVE;
				cmd.src_a = bvi2d_pkg::SRC_AX;
				cmd.src_b = bvi2d_pkg::SRC_DT;
			end
			bvi2d_pkg::ST_M2_J: begin
				cmd.wb    = bvi2d_pkg::WB_ADD_VX;
				cmd.src_a = bvi2d_pkg::SRC_AY;
				cmd.src_b = bvi2d_pkg::SRC_DT;
			end
			bvi2d_pkg::ST_M2_K: cmd.wb = bvi2d_pkg::WB_ADD_VY;
			bvi2d_pkg::ST_M2_L, bvi2d_pkg::ST_C_B: begin
				cmd.src_a = bvi2d_pkg::SRC_VX;
				cmd.src_b = bvi2d_pkg::SRC_VX;
			end
			bvi2d_pkg::ST_M2_M, bvi2d_pkg::ST_C_C: begin
				cmd.wb    = bvi2d_pkg::WB_SQ;
				cmd.src_a = bvi2d_pkg::SRC_VY;
				cmd.src_b = bvi2d_pkg::SRC_VY;
			end
			bvi2d_pkg::ST_M2_N: begin
				cmd.wb    = bvi2d_pkg::WB_SQ_ADD;
				cmd.src_a = bvi2d_pkg::SRC_MS;
				cmd.src_b = bvi2d_pkg::SRC_MS;
			end
			bvi2d_pkg::ST_C_D: begin
				cmd.wb    = bvi2d_pkg::WB_SQ_ADD;
				cmd.src_a = bvi2d_pkg::SRC_L;
				cmd.src_b = bvi2d_pkg::SRC_L;
			end
			bvi2d_pkg::ST_M2_O, bvi2d_pkg::ST_C_E: cmd.wb = bvi2d_pkg::WB_CMP;
			bvi2d_pkg::ST_C_A: cmd.misc = bvi2d_pkg::MISC_L_AMT;
			bvi2d_pkg::ST_R_SQ, bvi2d_pkg::ST_L_D: cmd.misc = bvi2d_pkg::MISC_SQRT;
			bvi2d_pkg::ST_R_SQW: if (sts.sqrt_done) cmd.misc = bvi2d_pkg::MISC_N_SAVE;
			bvi2d_pkg::ST_L_A: begin
				cmd.src_a = bvi2d_pkg::SRC_BX;
				cmd.src_b = bvi2d_pkg::SRC_BX;
			end
			bvi2d_pkg::ST_L_B: begin
				cmd.wb    = bvi2d_pkg::WB_SQ;
				cmd.src_a = bvi2d_pkg::SRC_BY;
				cmd.src_b = bvi2d_pkg::SRC_BY;
			end
			bvi2d_pkg::ST_L_C: cmd.wb = bvi2d_pkg::WB_SQ_ADD;
			bvi2d_pkg::ST_L_E: if (sts.sqrt_done) cmd.misc = bvi2d_pkg::MISC_L_SAVE;
			bvi2d_pkg::ST_RX_A: begin
				cmd.src_a = bvi2d_pkg::SRC_MAGX;
				cmd.src_b = bvi2d_pkg::SRC_L;
			end
			bvi2d_pkg::ST_RY_A: begin
				cmd.src_a = bvi2d_pkg::SRC_MAGY;
				cmd.src_b = bvi2d_pkg::SRC_L;
			end
			bvi2d_pkg::ST_RX_B, bvi2d_pkg::ST_RY_B: cmd.misc = bvi2d_pkg::MISC_DIV;
			bvi2d_pkg::ST_RX_C: if (sts.div_done) cmd.misc = bvi2d_pkg::MISC_QX;
			bvi2d_pkg::ST_RY_C: if (sts.div_done) cmd.misc = bvi2d_pkg::MISC_QY;
			bvi2d_pkg::ST_MV_A: begin
				cmd.src_a = bvi2d_pkg::SRC_VX;
				cmd.src_b = bvi2d_pkg::SRC_DT;
			end
			bvi2d_pkg::ST_MV_B: begin
				cmd.wb    = bvi2d_pkg::WB_MVX;
				cmd.src_a = bvi2d_pkg::SRC_VY;
				cmd.src_b = bvi2d_pkg::SRC_DT;
			end
			bvi2d_pkg::ST_MV_C: begin
				cmd.wb   = bvi2d_pkg::WB_MVY;
				cmd.misc = bvi2d_pkg::MISC_CLRA;
			end
			bvi2d_pkg::ST_FIN:
				if (!out_valid_q || out_ready) cmd.misc = bvi2d_pkg::MISC_PUBLISH;
			default: ;
		endcase
	end

	assign in_ready  = state_q == bvi2d_pkg::ST_IDLE;
	assign out_valid = out_valid_q;
endmodule
